[src/signature_predicted_rrip_replacement_top_defines.svh]
// assertion macros for the signature predicted rrip replacement block
// used by the top level; clock and reset are taken as clk and rst_n
`ifndef SIGNATURE_PREDICTED_RRIP_REPLACEMENT_TOP_DEFINES_SVH
`define SIGNATURE_PREDICTED_RRIP_REPLACEMENT_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define SPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SPR_ASSERT(lbl, prop, msg)
`define SPR_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

[src/spr_pkg.sv]
// package for the signature predicted rrip replacement block
// default sizes, constants, item kind codes and the sequencer state type
`timescale 1ns / 1ps
package spr_pkg;

  localparam int NUM_SETS_DEF      = 2048;
  localparam int NUM_WAYS_DEF      = 16;
  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int VALUE_BITS_DEF    = 2;

  localparam int PAGE_SHIFT = 12;
  localparam int SET_IN_W   = 11;
  localparam int WAY_IN_W   = 4;
  localparam int ADDR_W     = 64;
  localparam int CTR_W      = 3;

  localparam logic [CTR_W-1:0] CTR_MAX    = 3'd7;
  localparam logic [CTR_W-1:0] CTR_RESET  = 3'd4;
  localparam logic [CTR_W-1:0] THR_RESET  = 3'd4;

  localparam logic KIND_QUERY  = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROW,
    ST_CTR
  } spr_state_t;

endpackage

[src/spr_row_store.sv]
// set row memory: re-reference values and signatures of all ways of a set
// one write port shared with the clearing pass, registered read; uses spr_pkg
`timescale 1ns / 1ps
module spr_row_store import spr_pkg::*; #(
  parameter int NUM_SETS      = NUM_SETS_DEF,
  parameter int NUM_WAYS      = NUM_WAYS_DEF,
  parameter int VALUE_BITS    = VALUE_BITS_DEF,
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  localparam int SetW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1,
  localparam int SigW = $clog2(TABLE_ENTRIES),
  localparam int ValsW = NUM_WAYS * VALUE_BITS,
  localparam int SigsW = NUM_WAYS * SigW
) (
  input  logic             clk,
  input  logic             rd_en_i,
  input  logic [SetW-1:0]  rd_addr_i,
  input  logic             wr_en_i,
  input  logic [SetW-1:0]  wr_addr_i,
  input  logic [ValsW-1:0] wr_vals_i,
  input  logic [SigsW-1:0] wr_sigs_i,
  input  logic             clr_en_i,
  input  logic [SetW-1:0]  clr_addr_i,
  output logic [ValsW-1:0] rd_vals_o,
  output logic [SigsW-1:0] rd_sigs_o
);

  localparam int RowW = ValsW + SigsW;
  localparam logic [RowW-1:0] RowReset = {{SigsW{1'b0}}, {ValsW{1'b1}}};

  logic [RowW-1:0] row_mem [NUM_SETS];
  logic [RowW-1:0] rd_row_r;
  logic            mem_we;
  logic [SetW-1:0] mem_waddr;
  logic [RowW-1:0] mem_wdata;

  always_comb begin
    mem_we    = clr_en_i || wr_en_i;
    mem_waddr = clr_en_i ? clr_addr_i : wr_addr_i;
    mem_wdata = clr_en_i ? RowReset : {wr_sigs_i, wr_vals_i};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en_i) begin
      rd_row_r <= row_mem[rd_addr_i];
    end
  end

  assign rd_vals_o = rd_row_r[ValsW-1:0];
  assign rd_sigs_o = rd_row_r[RowW-1:ValsW];

endmodule

[src/spr_reuse_table.sv]
// reuse counter table indexed by signature, 3-bit saturating counters
// registered read, increment written back at the last read address; uses spr_pkg
`timescale 1ns / 1ps
module spr_reuse_table import spr_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  localparam int SigW = $clog2(TABLE_ENTRIES)
) (
  input  logic             clk,
  input  logic             rd_en_i,
  input  logic [SigW-1:0]  rd_addr_i,
  input  logic             inc_en_i,
  input  logic             clr_en_i,
  input  logic [SigW-1:0]  clr_addr_i,
  input  logic [CTR_W-1:0] thr_i,
  output logic             near_o
);

  logic [CTR_W-1:0] ctr_mem [TABLE_ENTRIES];
  logic [CTR_W-1:0] ctr_q_r;
  logic [SigW-1:0]  addr_r;
  logic             mem_we;
  logic [SigW-1:0]  mem_waddr;
  logic [CTR_W-1:0] mem_wdata;
  logic [CTR_W-1:0] ctr_inc;

  always_comb begin
    ctr_inc   = (ctr_q_r == CTR_MAX) ? CTR_MAX : ctr_q_r + CTR_W'(1);
    mem_we    = clr_en_i || inc_en_i;
    mem_waddr = clr_en_i ? clr_addr_i : addr_r;
    mem_wdata = clr_en_i ? CTR_RESET : ctr_inc;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ctr_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en_i) begin
      ctr_q_r <= ctr_mem[rd_addr_i];
      addr_r  <= rd_addr_i;
    end
  end

  assign near_o = (ctr_q_r >= thr_i);

endmodule

[src/spr_victim.sv]
// victim selection for one set row: ages all ways so the largest value
// becomes distant and picks the first distant way; uses spr_pkg
`timescale 1ns / 1ps
module spr_victim import spr_pkg::*; #(
  parameter int NUM_WAYS   = NUM_WAYS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int WayW  = $clog2(NUM_WAYS),
  localparam int ValsW = NUM_WAYS * VALUE_BITS
) (
  input  logic [ValsW-1:0] vals_i,
  output logic [ValsW-1:0] aged_o,
  output logic [WayW-1:0]  victim_o
);

  localparam logic [VALUE_BITS-1:0] Distant = '1;

  logic [NUM_WAYS-1:0]   ge_k [1 << VALUE_BITS];
  logic [VALUE_BITS-1:0] largest;
  logic [VALUE_BITS-1:0] lift;

  // per level: does any way reach it
  always_comb begin
    for (int k = 0; k < (1 << VALUE_BITS); k++) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        ge_k[k][w] = (vals_i[w*VALUE_BITS +: VALUE_BITS] >= VALUE_BITS'(k));
      end
    end
  end

  always_comb begin
    largest = '0;
    for (int k = 1; k < (1 << VALUE_BITS); k++) begin
      if (|ge_k[k]) begin
        largest = VALUE_BITS'(k);
      end
    end
    lift = Distant - largest;
    for (int w = 0; w < NUM_WAYS; w++) begin
      aged_o[w*VALUE_BITS +: VALUE_BITS] = vals_i[w*VALUE_BITS +: VALUE_BITS] + lift;
    end
    victim_o = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (vals_i[w*VALUE_BITS +: VALUE_BITS] == largest) begin
        victim_o = WayW'(w);
      end
    end
  end

endmodule

[src/signature_predicted_rrip_replacement_top.sv]
// top level of the signature predicted rrip replacement engine
// uses spr_pkg, spr_row_store, spr_reuse_table, spr_victim and the assertion macros
`timescale 1ns / 1ps
`include "signature_predicted_rrip_replacement_top_defines.svh"
// After reset the block sweeps its two memories to their reset contents, one set row and one
// counter entry per cycle, with in_stall high; configuration writes are taken throughout.
// Items are then handled one at a time: a victim query or a miss fill reads the set row, then
// modifies and writes it back, an update to a way at or above NUM_WAYS leaves the row as it
// is, and a hit adds a counter step before the write back because the counter address is the
// signature read from the set row memory. The result sits in an output register, so the next
// item is accepted while it waits to be taken. NUM_SETS and TABLE_ENTRIES must be powers of two; this is not checked.
module signature_predicted_rrip_replacement_top import spr_pkg::*; #(
  parameter int NUM_SETS      = NUM_SETS_DEF,
  parameter int NUM_WAYS      = NUM_WAYS_DEF,
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int VALUE_BITS    = VALUE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  input  logic [SET_IN_W-1:0] in_set_index,
  input  logic [WAY_IN_W-1:0] in_way,
  input  logic                in_hit,
  input  logic [ADDR_W-1:0]   in_pc,
  input  logic [ADDR_W-1:0]   in_paddr,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [WAY_IN_W-1:0] out_victim_way,
  output logic                out_inserted_distant,
  input  logic                cfg_we,
  input  logic [CTR_W-1:0]    cfg_wdata
);

  localparam int SetW  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WayW  = $clog2(NUM_WAYS);
  localparam int SigW  = $clog2(TABLE_ENTRIES);
  localparam int ValsW = NUM_WAYS * VALUE_BITS;
  localparam int SigsW = NUM_WAYS * SigW;
  localparam int ClrN  = (NUM_SETS > TABLE_ENTRIES) ? NUM_SETS : TABLE_ENTRIES;
  localparam int ClrW  = (ClrN > 1) ? $clog2(ClrN) : 1;
  localparam logic [VALUE_BITS-1:0] Distant = '1;

  spr_state_t          state_r, state_nxt;
  logic [ClrW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic                kind_r;
  logic [SetW-1:0]     set_r;
  logic [WAY_IN_W-1:0] way_r;
  logic                hit_r;
  logic [SigW-1:0]     sig_r;
  logic [CTR_W-1:0]    thr_r;
  logic                out_valid_r, out_valid_nxt;
  logic [WAY_IN_W-1:0] out_way_r, out_way_nxt;
  logic                out_dist_r, out_dist_nxt;

  logic                accept;
  logic                out_free;
  logic                finish;
  logic [SetW-1:0]     set_in;
  logic [SigW-1:0]     sig_in;
  logic                way_ok;
  logic [WayW-1:0]     way_idx;
  logic [SigW-1:0]     hit_sig;

  logic                row_rd_en;
  logic                row_wr_en;
  logic [ValsW-1:0]    row_wr_vals;
  logic [SigsW-1:0]    row_wr_sigs;
  logic [ValsW-1:0]    rd_vals;
  logic [SigsW-1:0]    rd_sigs;
  logic                row_clr_en;
  logic                ctr_clr_en;
  logic                ctr_rd_en;
  logic [SigW-1:0]     ctr_rd_addr;
  logic                ctr_inc;
  logic                ctr_near;
  logic [ValsW-1:0]    aged_vals;
  logic [WayW-1:0]     victim;

  assign set_in   = SetW'(32'(in_set_index) % NUM_SETS);
  assign sig_in   = SigW'(in_pc ^ (in_paddr >> PAGE_SHIFT));
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign way_ok   = (32'(way_r) < NUM_WAYS);
  assign way_idx  = WayW'(way_r);
  assign hit_sig  = rd_sigs[way_idx*SigW +: SigW];

  assign row_rd_en   = accept;
  assign row_clr_en  = (state_r == ST_CLEAR) && (32'(clr_cnt_r) < NUM_SETS);
  assign ctr_clr_en  = (state_r == ST_CLEAR) && (32'(clr_cnt_r) < TABLE_ENTRIES);
  assign ctr_rd_en   = accept ||
                       ((state_r == ST_ROW) && (kind_r == KIND_UPDATE) && way_ok && hit_r);
  assign ctr_rd_addr = accept ? sig_in : hit_sig;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    finish        = 1'b0;
    out_way_nxt   = out_way_r;
    out_dist_nxt  = out_dist_r;
    row_wr_en     = 1'b0;
    row_wr_vals   = rd_vals;
    row_wr_sigs   = rd_sigs;
    ctr_inc       = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + ClrW'(1);
        if (clr_cnt_r == ClrW'(ClrN - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_ROW;
        end
      end
      ST_ROW: begin
        priority if (kind_r == KIND_QUERY) begin
          row_wr_en    = 1'b1;
          row_wr_vals  = aged_vals;
          finish       = 1'b1;
          out_way_nxt  = WAY_IN_W'(victim);
          out_dist_nxt = 1'b0;
        end else if (!way_ok) begin
          finish       = 1'b1;
          out_way_nxt  = '0;
          out_dist_nxt = 1'b0;
        end else if (hit_r) begin
          state_nxt = ST_CTR;
        end else begin
          row_wr_en = 1'b1;
          row_wr_vals[way_idx*VALUE_BITS +: VALUE_BITS] = ctr_near ? '0 : Distant;
          row_wr_sigs[way_idx*SigW +: SigW] = sig_r;
          finish       = 1'b1;
          out_way_nxt  = '0;
          out_dist_nxt = !ctr_near;
        end
      end
      ST_CTR: begin
        row_wr_en = 1'b1;
        row_wr_vals[way_idx*VALUE_BITS +: VALUE_BITS] = '0;
        ctr_inc      = 1'b1;
        finish       = 1'b1;
        out_way_nxt  = '0;
        out_dist_nxt = 1'b0;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // result waits in its state until the output register is free
    if (finish && out_free) begin
      state_nxt = ST_IDLE;
    end else if (finish) begin
      out_way_nxt  = out_way_r;
      out_dist_nxt = out_dist_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (finish && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      thr_r       <= THR_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_way_r  <= out_way_nxt;
    out_dist_r <= out_dist_nxt;
    if (accept) begin
      kind_r <= in_kind;
      set_r  <= set_in;
      way_r  <= in_way;
      hit_r  <= in_hit;
      sig_r  <= sig_in;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_victim_way       = out_way_r;
  assign out_inserted_distant = out_dist_r;

  spr_row_store #(
    .NUM_SETS      (NUM_SETS),
    .NUM_WAYS      (NUM_WAYS),
    .VALUE_BITS    (VALUE_BITS),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_row_store (
    .clk        (clk),
    .rd_en_i    (row_rd_en),
    .rd_addr_i  (set_in),
    .wr_en_i    (row_wr_en),
    .wr_addr_i  (set_r),
    .wr_vals_i  (row_wr_vals),
    .wr_sigs_i  (row_wr_sigs),
    .clr_en_i   (row_clr_en),
    .clr_addr_i (SetW'(clr_cnt_r)),
    .rd_vals_o  (rd_vals),
    .rd_sigs_o  (rd_sigs)
  );

  spr_reuse_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_reuse_table (
    .clk        (clk),
    .rd_en_i    (ctr_rd_en),
    .rd_addr_i  (ctr_rd_addr),
    .inc_en_i   (ctr_inc),
    .clr_en_i   (ctr_clr_en),
    .clr_addr_i (SigW'(clr_cnt_r)),
    .thr_i      (thr_r),
    .near_o     (ctr_near)
  );

  spr_victim #(
    .NUM_WAYS   (NUM_WAYS),
    .VALUE_BITS (VALUE_BITS)
  ) u_victim (
    .vals_i   (rd_vals),
    .aged_o   (aged_vals),
    .victim_o (victim)
  );

  `SPR_ASSERT_NEVER(a_row_rw_overlap, row_rd_en && row_wr_en, "row read and write overlap")
  `SPR_ASSERT_NEVER(a_ctr_rd_inc_overlap, ctr_rd_en && ctr_inc, "counter read during increment")
  `SPR_ASSERT(a_victim_distant, (state_r == ST_ROW && kind_r == KIND_QUERY) |-> aged_vals[victim*VALUE_BITS +: VALUE_BITS] == Distant, "victim way not distant after ageing")
  `SPR_ASSERT(a_distant_way_zero, (out_valid && out_inserted_distant) |-> out_victim_way == '0, "distant fill with nonzero way")

endmodule

[tb/tb_signature_predicted_rrip_replacement_top.sv]
// testbench for signature_predicted_rrip_replacement_top: directed and random items checked
// against an in-bench predictor of the rrip values, line signatures and reuse counters
// depends on spr_pkg and the top level only
`timescale 1ns / 1ps
module tb_signature_predicted_rrip_replacement_top;
  import spr_pkg::*;

  localparam int SIG_W          = $clog2(TABLE_ENTRIES_DEF);
  localparam int LINES          = NUM_SETS_DEF * NUM_WAYS_DEF;
  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [VALUE_BITS_DEF-1:0] DISTANT_RRV = '1;

  typedef struct packed {
    logic                kind;
    logic [SET_IN_W-1:0] set_index;
    logic [WAY_IN_W-1:0] way;
    logic                hit;
    logic [ADDR_W-1:0]   pc;
    logic [ADDR_W-1:0]   paddr;
  } access_t;

  typedef struct packed {
    logic [WAY_IN_W-1:0] victim_way;
    logic                inserted_distant;
  } outcome_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_kind = KIND_QUERY;
  logic [SET_IN_W-1:0] in_set_index = '0;
  logic [WAY_IN_W-1:0] in_way = '0;
  logic                in_hit = 1'b0;
  logic [ADDR_W-1:0]   in_pc = '0;
  logic [ADDR_W-1:0]   in_paddr = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [WAY_IN_W-1:0] out_victim_way;
  logic                out_inserted_distant;
  logic                cfg_we = 1'b0;
  logic [CTR_W-1:0]    cfg_wdata = '0;

  // predictor state
  logic [VALUE_BITS_DEF-1:0] rrv_model [LINES];
  logic [SIG_W-1:0]          line_sig_model [LINES];
  logic [CTR_W-1:0]          reuse_ctr_model [TABLE_ENTRIES_DEF];
  logic [CTR_W-1:0]          threshold_model;

  outcome_t expected_outcomes [$];
  outcome_t due;
  logic [SET_IN_W-1:0] hot_sets [4];

  int send_gap_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  int results_checked = 0;
  int queries_sent = 0;
  int hits_sent = 0;
  int fills_sent = 0;
  int distant_fills = 0;
  int aged_sets = 0;

  signature_predicted_rrip_replacement_top i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_kind              (in_kind),
    .in_set_index         (in_set_index),
    .in_way               (in_way),
    .in_hit               (in_hit),
    .in_pc                (in_pc),
    .in_paddr             (in_paddr),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_victim_way       (out_victim_way),
    .out_inserted_distant (out_inserted_distant),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected result victim_way %0d inserted_distant %0d", $time,
                 out_victim_way, out_inserted_distant);
        errors++;
      end else begin
        due = expected_outcomes.pop_front();
        if (out_victim_way !== due.victim_way) begin
          $display("%0t: victim_way expected %0d actual %0d", $time, due.victim_way,
                   out_victim_way);
          errors++;
        end
        if (out_inserted_distant !== due.inserted_distant) begin
          $display("%0t: inserted_distant expected %0d actual %0d", $time,
                   due.inserted_distant, out_inserted_distant);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
        $display("tb_signature_predicted_rrip_replacement_top failed");
        $finish;
      end
    end
  end

  function automatic void reset_model();
    int i;
    for (i = 0; i < LINES; i++) begin
      rrv_model[i] = DISTANT_RRV;
      line_sig_model[i] = '0;
    end
    for (i = 0; i < TABLE_ENTRIES_DEF; i++) reuse_ctr_model[i] = CTR_RESET;
    threshold_model = THR_RESET;
  endfunction

  function automatic outcome_t predict_outcome(access_t it);
    outcome_t res;
    int base;
    int line;
    int w;
    bit found;
    logic [VALUE_BITS_DEF-1:0] top;
    logic [ADDR_W-1:0] folded;
    logic [SIG_W-1:0] sig;
    res = '0;
    base = int'(it.set_index) * NUM_WAYS_DEF;
    line = base + int'(it.way);
    if (it.kind == KIND_QUERY) begin
      top = '0;
      for (w = 0; w < NUM_WAYS_DEF; w++) if (rrv_model[base + w] > top) top = rrv_model[base + w];
      if (top != DISTANT_RRV) begin
        aged_sets++;
        for (w = 0; w < NUM_WAYS_DEF; w++) rrv_model[base + w] += DISTANT_RRV - top;
      end
      found = 1'b0;
      for (w = 0; w < NUM_WAYS_DEF; w++) begin
        if (!found && rrv_model[base + w] == DISTANT_RRV) begin
          res.victim_way = w[WAY_IN_W-1:0];
          found = 1'b1;
        end
      end
    end else if (it.hit) begin
      sig = line_sig_model[line];
      rrv_model[line] = '0;
      if (reuse_ctr_model[sig] != CTR_MAX) reuse_ctr_model[sig]++;
    end else begin
      folded = it.pc ^ (it.paddr >> PAGE_SHIFT);
      sig = folded[SIG_W-1:0];
      line_sig_model[line] = sig;
      if (reuse_ctr_model[sig] >= threshold_model) begin
        rrv_model[line] = '0;
      end else begin
        rrv_model[line] = DISTANT_RRV;
        res.inserted_distant = 1'b1;
        distant_fills++;
      end
    end
    return res;
  endfunction

  function automatic access_t build_access(logic kind, int set_sel, int way_sel, logic hit,
                                           logic [ADDR_W-1:0] pc, logic [ADDR_W-1:0] paddr);
    access_t it;
    it.kind = kind;
    it.set_index = SET_IN_W'(set_sel);
    it.way = WAY_IN_W'(way_sel);
    it.hit = hit;
    it.pc = pc;
    it.paddr = paddr;
    return it;
  endfunction

  // most signatures come from a small pool so that counters climb and saturate
  function automatic access_t make_update(logic [SET_IN_W-1:0] set_sel,
                                          logic [WAY_IN_W-1:0] way_sel, logic hit);
    access_t it;
    logic [SIG_W-1:0] sig;
    it = build_access(KIND_UPDATE, int'(set_sel), int'(way_sel), hit, {$urandom, $urandom},
                      {$urandom, $urandom});
    if ($urandom_range(0, 3) != 0) begin
      sig = SIG_W'($urandom_range(0, 7) * 61);
      it.pc[SIG_W-1:0] = sig ^ it.paddr[PAGE_SHIFT +: SIG_W];
    end
    return it;
  endfunction

  function automatic logic [SET_IN_W-1:0] pick_set();
    if ($urandom_range(0, 99) < 85) return hot_sets[$urandom_range(0, 3)];
    return SET_IN_W'($urandom_range(0, NUM_SETS_DEF - 1));
  endfunction

  function automatic access_t random_access();
    access_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it = make_update(pick_set(), WAY_IN_W'($urandom_range(0, NUM_WAYS_DEF - 1)), pick < 65);
    if (pick < 35) it.kind = KIND_QUERY;
    return it;
  endfunction

  task automatic send_item(input access_t it, output outcome_t res);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= it.kind;
    in_set_index <= it.set_index;
    in_way       <= it.way;
    in_hit       <= it.hit;
    in_pc        <= it.pc;
    in_paddr     <= it.paddr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = predict_outcome(it);
    expected_outcomes.push_back(res);
    items_sent++;
    if (it.kind == KIND_QUERY) queries_sent++;
    else if (it.hit) hits_sent++;
    else fills_sent++;
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [CTR_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    threshold_model = value;
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed_fields();
    outcome_t res;
    send_item(build_access(KIND_QUERY, 0, 9, 1'b1, '1, '1), res);
    send_item(build_access(KIND_UPDATE, 0, 0, 1'b0, '0, '0), res);
    send_item(build_access(KIND_QUERY, 0, 0, 1'b0, '0, '0), res);
    send_item(build_access(KIND_UPDATE, 0, 0, 1'b1, '1, '0), res);
    send_item(build_access(KIND_UPDATE, NUM_SETS_DEF - 1, NUM_WAYS_DEF - 1, 1'b0, '1, '1), res);
    send_item(build_access(KIND_UPDATE, NUM_SETS_DEF - 1, NUM_WAYS_DEF - 2, 1'b0,
                           64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_F000), res);
    send_item(build_access(KIND_UPDATE, NUM_SETS_DEF - 1, NUM_WAYS_DEF - 1, 1'b1,
                           64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA), res);
    send_item(build_access(KIND_QUERY, NUM_SETS_DEF - 1, NUM_WAYS_DEF - 1, 1'b1, '0, '1), res);
    send_item(build_access(KIND_QUERY, 1234, 5, 1'b0, '1, '0), res);
  endtask

  // all but the last two ways of the last set near, then queries that must lift the whole set
  task automatic test_set_aging();
    outcome_t res;
    int w;
    for (w = 0; w < NUM_WAYS_DEF - 2; w++)
      send_item(build_access(KIND_UPDATE, NUM_SETS_DEF - 1, w, 1'b1, '0, '0), res);
    send_item(build_access(KIND_QUERY, NUM_SETS_DEF - 1, 0, 1'b0, '0, '0), res);
    send_item(build_access(KIND_UPDATE, NUM_SETS_DEF - 1, 0, 1'b1, '0, '0), res);
    send_item(build_access(KIND_QUERY, NUM_SETS_DEF - 1, 0, 1'b0, '0, '0), res);
  endtask

  task automatic test_threshold_extremes();
    outcome_t res;
    drain_block();
    write_threshold(3'd7);
    send_item(build_access(KIND_UPDATE, 5, 3, 1'b0, 64'h155, 64'h0), res);
    send_item(build_access(KIND_QUERY, 5, 0, 1'b0, '0, '0), res);
    drain_block();
    write_threshold(3'd0);
    send_item(build_access(KIND_UPDATE, 5, 0, 1'b0, 64'h2AA, 64'h0), res);
    send_item(build_access(KIND_QUERY, 5, 0, 1'b0, '0, '0), res);
  endtask

  // mostly query then fill of the chosen way, the rest single random items
  task automatic test_random_traffic(input int count, input int gap_pct, input int stall,
                                     input logic [CTR_W-1:0] thr, input bit pause_midway);
    outcome_t res;
    access_t it;
    int sent;
    int i;
    bit paused;
    drain_block();
    write_threshold(thr);
    send_gap_pct = gap_pct;
    stall_pct = stall;
    for (i = 0; i < 4; i++) hot_sets[i] = SET_IN_W'($urandom_range(0, NUM_SETS_DEF - 1));
    sent = 0;
    paused = 1'b0;
    while (sent < count) begin
      if (pause_midway && !paused && sent >= count / 2) begin
        drain_block();
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 45) begin
        it = make_update(pick_set(), WAY_IN_W'($urandom_range(0, NUM_WAYS_DEF - 1)),
                         1'($urandom_range(0, 1)));
        it.kind = KIND_QUERY;
        send_item(it, res);
        send_item(make_update(it.set_index, res.victim_way, 1'b0), res);
        sent += 2;
      end else begin
        send_item(random_access(), res);
        sent++;
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_fields();
    test_set_aging();
    test_threshold_extremes();
    test_random_traffic(490, 37, 80, CTR_W'($urandom_range(1, 6)), 1'b1);
    test_random_traffic(490, 80, 37, 3'd0, 1'b0);
    test_random_traffic(490, 0, 0, 3'd7, 1'b0);
    drain_block();
    $display("%0d items (%0d queries, %0d hits, %0d fills), %0d results checked", items_sent,
             queries_sent, hits_sent, fills_sent, results_checked);
    $display("%0d fills inserted distant, %0d queries aged their set", distant_fills, aged_sets);
    if (errors == 0) begin
      $display("tb_signature_predicted_rrip_replacement_top passed");
    end else begin
      $display("tb_signature_predicted_rrip_replacement_top failed");
    end
    $finish;
  end

endmodule
